// File: rtl/ssor_pkg.sv
`default_nettype none

package ssor_pkg;

    // Field widths
    localparam int ADDR_W    = 48;
    localparam int SIZE_W    = 32;
    localparam int LEN_W     = 16;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 3;
    localparam int CNT_OUT_W = 6;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_REJECT = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NONEXT = 3'd4;

    localparam logic [LEN_W-1:0] DEFAULT_BLOCK_LENGTH = 16'd2000;

    // Insert broadcast to every cell
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
    } ins_t;

    // Resolve probe handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              done;
        logic              two;
        logic [STAT_W-1:0] status;
        logic [SIZE_W-1:0] loc;
        logic [ADDR_W-1:0] addr0;
        logic [LEN_W-1:0]  len0;
        logic [ADDR_W-1:0] addr1;
        logic [LEN_W-1:0]  len1;
    } probe_t;

endpackage

`default_nettype wire

// File: rtl/sorted_segment_offset_resolver.sv
`default_nettype none

// Sorted segment table with offset resolver. Segments live in a row of
// TABLE_DEPTH cells in ascending base order; an accepted insert request is
// registered and written into the row on the next cycle, and the block
// takes no new request meanwhile. A clear request yields one result, and
// a request with the unused command code is dropped with no result. A
// resolve request sends a probe down the row, one cell per cycle; after it
// leaves the last cell the probe is held in walk_reg and its results are
// pushed once the output queue has room. Results pass through
// a two-deep output queue, so a request can be taken while a result waits.
// Entries past the held count are never read; no clearing pass runs after
// reset.
module sorted_segment_offset_resolver
    import ssor_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [LEN_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CMD_W-1:0]     command,
    input  wire logic [ADDR_W-1:0]    load_bias,
    input  wire logic [ADDR_W-1:0]    segment_vaddr,
    input  wire logic [SIZE_W-1:0]    segment_size,
    input  wire logic                 perm_read,
    input  wire logic                 perm_write,
    input  wire logic                 perm_exec,
    input  wire logic [SIZE_W-1:0]    linear_offset,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ADDR_W-1:0]         range_address,
    output logic [LEN_W-1:0]          range_length,
    output logic                      last,
    output logic [STAT_W-1:0]         status,
    output logic [CNT_OUT_W-1:0]      entry_count
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_WALK,
        S_PUSH
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    addr;
        logic [LEN_W-1:0]     len;
        logic                 last;
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] count;
    } result_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [LEN_W-1:0]  block_length_reg;
    logic [ADDR_W-1:0] ins_base_reg, ins_base_next;
    logic [SIZE_W-1:0] ins_size_reg, ins_size_next;
    logic [STAT_W-1:0] ins_status_reg, ins_status_next;
    probe_t            walk_reg, walk_next;
    result_t           q_reg [2];
    result_t           q_next [2];
    logic [1:0]        q_cnt_reg, q_cnt_next;

    logic              in_acc;
    logic              pop;
    logic [1:0]        cnt_pop;
    logic [1:0]        push_n;
    result_t           push0, push1;
    ins_t              ins;
    probe_t            launch;
    logic              seg_ok;

    logic [ADDR_W-1:0] cell_base [TABLE_DEPTH];
    logic [SIZE_W-1:0] cell_size [TABLE_DEPTH];
    logic              cell_lt   [TABLE_DEPTH];
    probe_t            probe_chain [TABLE_DEPTH+1];

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && (q_cnt_reg != 2'd2);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = (q_cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign cnt_pop   = q_cnt_reg - {1'b0, pop};

    assign seg_ok = (segment_size != '0) && perm_read && perm_exec && !perm_write;

    // Broadcast the registered insert to the row
    assign ins.en   = (state_reg == S_INS) && (ins_status_reg == ST_OK);
    assign ins.base = ins_base_reg;
    assign ins.size = ins_size_reg;

    // Launch a probe into the first cell
    always_comb
    begin
        launch        = '0;
        launch.valid  = in_acc && (command == CMD_RESOLVE);
        launch.status = ST_OK;
        launch.loc    = linear_offset;
    end
    assign probe_chain[0] = launch;

    // Row of table cells
    for (genvar j = 0; j < TABLE_DEPTH; j++)
    begin : g_cell
        logic              l_lt;
        logic [ADDR_W-1:0] l_base;
        logic [SIZE_W-1:0] l_size;
        logic [ADDR_W-1:0] n_base;

        if (j == 0)
        begin : g_first
            assign l_lt   = 1'b0;
            assign l_base = '0;
            assign l_size = '0;
        end
        else
        begin : g_inner
            assign l_lt   = cell_lt[j-1];
            assign l_base = cell_base[j-1];
            assign l_size = cell_size[j-1];
        end

        if (j == TABLE_DEPTH - 1)
        begin : g_end
            assign n_base = '0;
        end
        else
        begin : g_mid
            assign n_base = cell_base[j+1];
        end

        ssor_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ins          (ins),
            .in_use       (count_reg > CW'(j)),
            .at_tail      (count_reg == CW'(j)),
            .next_in_use  (count_reg > CW'(j + 1)),
            .left_lt      (l_lt),
            .left_base    (l_base),
            .left_size    (l_size),
            .next_base    (n_base),
            .block_length (block_length_reg),
            .probe_in     (probe_chain[j]),
            .lt           (cell_lt[j]),
            .base         (cell_base[j]),
            .size         (cell_size[j]),
            .probe_out    (probe_chain[j+1])
        );
    end

    // Sequence requests and build results
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ins_base_next   = ins_base_reg;
        ins_size_next   = ins_size_reg;
        ins_status_next = ins_status_reg;
        walk_next       = walk_reg;
        push_n          = 2'd0;
        push0           = '0;
        push1           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (command)
                        CMD_INSERT:
                        begin
                            ins_base_next = load_bias + segment_vaddr;
                            ins_size_next = segment_size;
                            if (!seg_ok)
                            begin
                                ins_status_next = ST_REJECT;
                            end
                            else if (count_reg >= CW'(TABLE_DEPTH))
                            begin
                                ins_status_next = ST_FULL;
                            end
                            else
                            begin
                                ins_status_next = ST_OK;
                            end
                            state_next = S_INS;
                        end
                        CMD_RESOLVE:
                        begin
                            state_next = S_WALK;
                        end
                        CMD_CLEAR:
                        begin
                            count_next   = '0;
                            push_n       = 2'd1;
                            push0.last   = 1'b1;
                            push0.status = ST_OK;
                            push0.count  = '0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                if (ins_status_reg == ST_OK)
                begin
                    count_next = count_reg + CW'(1);
                end
                push_n       = 2'd1;
                push0.last   = 1'b1;
                push0.status = ins_status_reg;
                push0.count  = CNT_OUT_W'(count_next);
                state_next   = S_IDLE;
            end
            S_WALK:
            begin
                if (probe_chain[TABLE_DEPTH].valid)
                begin
                    walk_next = probe_chain[TABLE_DEPTH];
                    // Probe left the row unmatched: offset out of range
                    if (!probe_chain[TABLE_DEPTH].done)
                    begin
                        walk_next.two    = 1'b0;
                        walk_next.status = ST_RANGE;
                        walk_next.addr0  = '0;
                        walk_next.len0   = '0;
                    end
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                push0.addr   = walk_reg.addr0;
                push0.len    = walk_reg.len0;
                push0.last   = !walk_reg.two;
                push0.status = walk_reg.status;
                push0.count  = CNT_OUT_W'(count_reg);
                push1.addr   = walk_reg.addr1;
                push1.len    = walk_reg.len1;
                push1.last   = 1'b1;
                push1.status = ST_OK;
                push1.count  = CNT_OUT_W'(count_reg);
                if (walk_reg.two)
                begin
                    if (cnt_pop == 2'd0)
                    begin
                        push_n     = 2'd2;
                        state_next = S_IDLE;
                    end
                end
                else if (cnt_pop != 2'd2)
                begin
                    push_n     = 2'd1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output queue: drop the head on a pop, append pushed results
    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        if (pop)
        begin
            q_next[0] = q_reg[1];
        end
        if (push_n != 2'd0)
        begin
            q_next[cnt_pop[0]] = push0;
        end
        if (push_n == 2'd2)
        begin
            q_next[1] = push1;
        end
        q_cnt_next = cnt_pop + push_n;
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            q_cnt_reg        <= 2'd0;
            block_length_reg <= DEFAULT_BLOCK_LENGTH;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            q_cnt_reg      <= q_cnt_next;
            ins_base_reg   <= ins_base_next;
            ins_size_reg   <= ins_size_next;
            ins_status_reg <= ins_status_next;
            walk_reg       <= walk_next;
            q_reg[0]       <= q_next[0];
            q_reg[1]       <= q_next[1];
            if (cfg_valid)
            begin
                block_length_reg <= cfg_data;
            end
        end
    end

    assign range_address = q_reg[0].addr;
    assign range_length  = q_reg[0].len;
    assign last          = q_reg[0].last;
    assign status        = q_reg[0].status;
    assign entry_count   = q_reg[0].count;

endmodule

`default_nettype wire

// File: rtl/ssor_cell.sv
`default_nettype none

module ssor_cell
    import ssor_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ins_t              ins,
    input  wire logic              in_use,
    input  wire logic              at_tail,
    input  wire logic              next_in_use,
    input  wire logic              left_lt,
    input  wire logic [ADDR_W-1:0] left_base,
    input  wire logic [SIZE_W-1:0] left_size,
    input  wire logic [ADDR_W-1:0] next_base,
    input  wire logic [LEN_W-1:0]  block_length,
    input  wire probe_t            probe_in,
    output logic                   lt,
    output logic [ADDR_W-1:0]      base,
    output logic [SIZE_W-1:0]      size,
    output probe_t                 probe_out
);

    logic [ADDR_W-1:0] base_reg, base_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    probe_t            probe_reg, probe_next;
    logic [SIZE_W:0]   reach;
    logic [SIZE_W:0]   head;
    logic [SIZE_W-1:0] tail;
    logic              fits;

    // New segment sorts below this entry
    assign lt = in_use && (ins.base < base_reg);

    // Shift up from the left neighbor, take the new segment, or hold
    always_comb
    begin
        base_next = base_reg;
        size_next = size_reg;
        if (ins.en)
        begin
            if (left_lt)
            begin
                base_next = left_base;
                size_next = left_size;
            end
            else if (in_use ? lt : at_tail)
            begin
                base_next = ins.base;
                size_next = ins.size;
            end
        end
    end

    // Step the probe through this entry
    always_comb
    begin
        probe_next = probe_in;
        reach      = {1'b0, probe_in.loc} + {{(SIZE_W+1-LEN_W){1'b0}}, block_length};
        fits       = reach < {1'b0, size_reg};
        tail       = size_reg - probe_in.loc;
        head       = reach - {1'b0, size_reg};
        if (probe_in.valid && !probe_in.done)
        begin
            if (!in_use)
            begin
                probe_next.done   = 1'b1;
                probe_next.two    = 1'b0;
                probe_next.status = ST_RANGE;
                probe_next.addr0  = '0;
                probe_next.len0   = '0;
            end
            else if (probe_in.loc > size_reg)
            begin
                probe_next.loc = probe_in.loc - size_reg;
            end
            else
            begin
                probe_next.done   = 1'b1;
                probe_next.two    = 1'b0;
                probe_next.status = ST_OK;
                probe_next.addr0  = base_reg + {{(ADDR_W-SIZE_W){1'b0}}, probe_in.loc};
                if (fits)
                begin
                    probe_next.len0 = block_length;
                end
                else if (!next_in_use)
                begin
                    probe_next.len0   = tail[LEN_W-1:0];
                    probe_next.status = ST_NONEXT;
                end
                else
                begin
                    probe_next.len0  = tail[LEN_W-1:0];
                    probe_next.addr1 = next_base;
                    probe_next.len1  = head[LEN_W-1:0];
                    probe_next.two   = 1'b1;
                end
            end
        end
    end

    // Hold the table entry
    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        size_reg <= size_next;
    end

    // Advance the probe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg.valid <= 1'b0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign base      = base_reg;
    assign size      = size_reg;
    assign probe_out = probe_reg;

endmodule

`default_nettype wire
